[sv/fla_pkg.sv]
// Package for the free list allocator: types, codes and defaults.
package fla_pkg;

  localparam int unsigned ArenaUnitsDef = 65536;
  localparam int unsigned UnitBytesDef  = 16;
  localparam logic [15:0] HeapLimitRst  = 16'hFFFF;
  localparam logic [15:0] MinGrowRst    = 16'd1024;

  localparam logic [1:0] CmdAlloc  = 2'd0;
  localparam logic [1:0] CmdFree   = 2'd1;
  localparam logic [1:0] CmdDonate = 2'd2;
  localparam logic [1:0] CmdArray  = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StInval = 2'd1;
  localparam logic [1:0] StNoMem = 2'd2;

  localparam logic RegHeapLimit = 1'b0;
  localparam logic RegMinGrow   = 1'b1;

  // One header unit: next free block and size in units.
  typedef struct packed {
    logic [15:0] next;
    logic [16:0] size;
  } hdr_t;

  // Memory access request from the sequencer to the header store.
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [19:0] addr;
    hdr_t        wdata;
  } mem_req_t;

endpackage

[sv/fla_hdr_mem.sv]
// Header store: one synchronous RAM port, registered read data.
module fla_hdr_mem #(
  parameter int unsigned ARENA_UNITS = fla_pkg::ArenaUnitsDef
) (
  input  logic              clk_i,
  input  fla_pkg::mem_req_t req_i,
  output fla_pkg::hdr_t     rdata_o
);
  import fla_pkg::*;

  localparam int unsigned AW = $clog2(ARENA_UNITS);

  hdr_t mem [ARENA_UNITS];
  hdr_t rdata_q;
  logic in_arena;

  // Out-of-arena accesses read zero and drop writes.
  assign in_arena = (req_i.addr < 20'(ARENA_UNITS));

  always_ff @(posedge clk_i) begin
    if (req_i.wr && in_arena) begin
      mem[req_i.addr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= in_arena ? mem[req_i.addr[AW-1:0]] : '0;
    end
  end

  assign rdata_o = rdata_q;
endmodule

[sv/fla_seq.sv]
// Command sequencer: walks the free list through the header store.
module fla_seq #(
  parameter int unsigned ARENA_UNITS = fla_pkg::ArenaUnitsDef,
  parameter int unsigned UNIT_BYTES  = fla_pkg::UnitBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              hold_i,
  input  logic [1:0]        cmd_i,
  input  logic [36:0]       bytes_i,
  input  logic [15:0]       baddr_i,
  input  logic [15:0]       region_i,
  input  logic [15:0]       heap_limit_i,
  input  logic [15:0]       min_grow_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [15:0]       addr_o,
  output fla_pkg::mem_req_t req_o,
  input  fla_pkg::hdr_t     rdata_i
);
  import fla_pkg::*;

  localparam int unsigned UB_SH = $clog2(UNIT_BYTES);
  localparam logic [18:0] WALK_LIMIT = 19'(2 * ARENA_UNITS + 8);
  localparam logic [19:0] CAP_MAX = 20'(ARENA_UNITS - 1);

  typedef enum logic [21:0] {
    S_IDLE    = 22'h000001, S_INIT    = 22'h000002, S_DISP    = 22'h000004,
    S_ARD     = 22'h000008, S_AWAIT   = 22'h000010, S_ACHK    = 22'h000020,
    S_AUNL    = 22'h000040, S_ASPL    = 22'h000080, S_GROW    = 22'h000100,
    S_PRD     = 22'h000200, S_PWAIT   = 22'h000400, S_PSZ     = 22'h000800,
    S_PWALK   = 22'h001000, S_PWWAIT  = 22'h002000, S_PNRD    = 22'h004000,
    S_PNWAIT  = 22'h008000, S_PPRD    = 22'h010000, S_PPWAIT  = 22'h020000,
    S_PBWR    = 22'h040000, S_PPWR    = 22'h080000, S_DONE    = 22'h100000,
    S_AUNLRD  = 22'h200000
  } state_e;

  state_e      state_q, state_d;
  logic        ready_q, ready_d;
  logic [15:0] rover_q, rover_d;
  logic [16:0] brk_q, brk_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [1:0]  st_q, st_d;
  logic [15:0] ad_q, ad_d;
  logic [33:0] units_q, units_d;
  logic [15:0] prev_q, prev_d;
  logic [15:0] p_q, p_d;
  logic [15:0] bp_q, bp_d;
  logic [16:0] bsz_q, bsz_d;
  logic [15:0] pn_q, pn_d;
  logic [16:0] psz_q, psz_d;
  logic [15:0] nn_q, nn_d;
  logic [16:0] nsz_q, nsz_d;
  logic [18:0] steps_q, steps_d;
  logic        grow_q, grow_d;
  mem_req_t    req;
  logic [33:0] nu;
  logic [19:0] cap;
  logic [16:0] split;
  logic        hi_merge, lo_merge;

  assign cap = ({4'd0, heap_limit_i} > CAP_MAX) ? CAP_MAX : {4'd0, heap_limit_i};
  assign nu = (units_q < {18'd0, min_grow_i}) ? {18'd0, min_grow_i} : units_q;
  assign split = rdata_i.size - units_q[16:0];
  assign hi_merge = (({2'd0, bp_q} + {1'b0, bsz_q}) == {2'd0, pn_q});
  assign lo_merge = (({2'd0, p_q} + {1'b0, psz_q}) == {2'd0, bp_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
      rover_q <= '0;
      brk_q   <= 17'd1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      rover_q <= rover_d;
      brk_q   <= brk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;  st_q <= st_d;  ad_q <= ad_d;  units_q <= units_d;
    prev_q <= prev_d;  p_q <= p_d;  bp_q <= bp_d;  bsz_q <= bsz_d;
    pn_q <= pn_d;  psz_q <= psz_d;  nn_q <= nn_d;  nsz_q <= nsz_d;
    steps_q <= steps_d;  grow_q <= grow_d;
  end

  always_comb begin
    state_d = state_q;  ready_d = ready_q;  rover_d = rover_q;  brk_d = brk_q;
    cmd_d = cmd_q;  st_d = st_q;  ad_d = ad_q;  units_d = units_q;
    prev_d = prev_q;  p_d = p_q;  bp_d = bp_q;  bsz_d = bsz_q;
    pn_d = pn_q;  psz_d = psz_q;  nn_d = nn_q;  nsz_d = nsz_q;
    steps_d = steps_q;  grow_d = grow_q;
    req = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          st_d = StOk;
          ad_d = '0;
          grow_d = 1'b0;
          steps_d = '0;
          units_d = 34'((bytes_i + 37'(UNIT_BYTES - 1)) >> UB_SH) + 34'd1;
          bp_d = (cmd_i == CmdFree) ? baddr_i - 16'd1 : baddr_i;
          bsz_d = {1'b0, region_i};
          state_d = ready_q ? S_DISP : S_INIT;
          if (cmd_i == CmdAlloc || cmd_i == CmdArray) begin
            if (bytes_i == '0) begin
              st_d = StInval;
              state_d = ready_q ? S_DONE : S_INIT;
            end
          end
        end
      end
      // Build the sentinel once.
      S_INIT: begin
        req.wr = 1'b1;
        req.addr = '0;
        ready_d = 1'b1;
        rover_d = '0;
        state_d = (st_q != StOk) ? S_DONE : S_DISP;
      end
      S_DISP: begin
        if (cmd_q == CmdDonate || cmd_q == CmdFree) begin
          state_d = S_PRD;
        end else begin
          prev_d = rover_q;
          p_d = rover_q;
          state_d = S_ARD;
          steps_d = 19'h7FFFF;
        end
      end
      // Allocation walk: read header at p.
      S_ARD: begin
        req.rd = 1'b1;
        req.addr = {4'd0, (steps_q == 19'h7FFFF) ? rover_q : p_q};
        state_d = S_AWAIT;
      end
      S_AWAIT: begin
        if (steps_q == 19'h7FFFF) begin
          p_d = rdata_i.next;
          steps_d = '0;
          state_d = S_ARD;
        end else begin
          state_d = S_ACHK;
        end
      end
      S_ACHK: begin
        if ({17'd0, rdata_i.size} >= units_q) begin
          rover_d = prev_q;
          if ({17'd0, rdata_i.size} == units_q) begin
            nn_d = rdata_i.next;
            ad_d = p_q + 16'd1;
            state_d = S_AUNLRD;
          end else begin
            req.wr = 1'b1;
            req.addr = {4'd0, p_q};
            req.wdata = '{next: rdata_i.next, size: split};
            nsz_d = split;
            state_d = S_ASPL;
          end
        end else if (p_q == rover_q && !grow_q) begin
          state_d = S_GROW;
          pn_d = rdata_i.next;
        end else begin
          grow_d = 1'b0;
          prev_d = p_q;
          p_d = rdata_i.next;
          steps_d = steps_q + 19'd1;
          state_d = (steps_q + 19'd1 > WALK_LIMIT) ? S_DONE : S_ARD;
          if (steps_q + 19'd1 > WALK_LIMIT) st_d = StNoMem;
        end
      end
      S_AUNLRD: begin
        req.rd = 1'b1;
        req.addr = {4'd0, prev_q};
        state_d = S_AUNL;
      end
      S_AUNL: begin
        req.wr = 1'b1;
        req.addr = {4'd0, prev_q};
        req.wdata = '{next: nn_q, size: rdata_i.size};
        state_d = S_DONE;
      end
      // Tail header may land past the arena; the store drops that write.
      S_ASPL: begin
        req.wr = 1'b1;
        req.addr = {4'd0, p_q} + {3'd0, nsz_q};
        req.wdata = '{next: 16'd0, size: units_q[16:0]};
        ad_d = p_q + nsz_q[15:0] + 16'd1;
        state_d = S_DONE;
      end
      // Take a fresh region from the break and free it into the list.
      S_GROW: begin
        if ({17'd0, brk_q} + nu > {14'd0, cap} + 34'd1) begin
          st_d = StNoMem;
          state_d = S_DONE;
        end else begin
          req.wr = 1'b1;
          req.addr = {3'd0, brk_q};
          req.wdata = '{next: 16'd0, size: nu[16:0]};
          bp_d = brk_q[15:0];
          bsz_d = nu[16:0];
          brk_d = brk_q + nu[16:0];
          grow_d = 1'b1;
          p_d = rover_q;
          state_d = S_PWALK;
        end
      end
      S_PRD: begin
        req.rd = 1'b1;
        req.addr = {4'd0, bp_q};
        state_d = S_PWAIT;
      end
      S_PWAIT: state_d = S_PSZ;
      S_PSZ: begin
        p_d = rover_q;
        steps_d = '0;
        if (cmd_q == CmdDonate) begin
          // Replace only the size of the donated header; keep its link.
          req.wr = 1'b1;
          req.addr = {4'd0, bp_q};
          req.wdata = '{next: rdata_i.next, size: bsz_q};
          if (bsz_q == '0) begin
            st_d = StInval;
            state_d = S_DONE;
          end else begin
            state_d = S_PWALK;
          end
        end else begin
          bsz_d = rdata_i.size;
          if (rdata_i.size == '0) begin
            st_d = StInval;
            state_d = S_DONE;
          end else begin
            state_d = S_PWALK;
          end
        end
      end
      // Insert walk: find p < bp < next(p), or wrap where next(p) <= p.
      S_PWALK: begin
        req.rd = 1'b1;
        req.addr = {4'd0, p_q};
        state_d = S_PWWAIT;
      end
      S_PWWAIT: begin
        psz_d = rdata_i.size;
        pn_d = rdata_i.next;
        if ((bp_q > p_q && bp_q < rdata_i.next) ||
            (p_q >= rdata_i.next && (bp_q > p_q || bp_q < rdata_i.next))) begin
          state_d = S_PNRD;
        end else begin
          p_d = rdata_i.next;
          steps_d = steps_q + 19'd1;
          if (steps_q + 19'd1 > WALK_LIMIT) begin
            st_d = grow_q ? StNoMem : StInval;
            state_d = S_DONE;
          end else begin
            state_d = S_PWALK;
          end
        end
      end
      S_PNRD: begin
        req.rd = 1'b1;
        req.addr = {4'd0, pn_q};
        state_d = S_PNWAIT;
      end
      S_PNWAIT: state_d = S_PPRD;
      S_PPRD: begin
        nsz_d = rdata_i.size;
        nn_d = rdata_i.next;
        state_d = S_PBWR;
      end
      // Merge with upper neighbor.
      S_PBWR: begin
        req.wr = 1'b1;
        req.addr = {4'd0, bp_q};
        if (hi_merge) begin
          bsz_d = bsz_q + nsz_q;
          nn_d = nn_q;
        end else begin
          nn_d = pn_q;
        end
        req.wdata = '{next: hi_merge ? nn_q : pn_q,
                      size: hi_merge ? bsz_q + nsz_q : bsz_q};
        state_d = S_PPWR;
      end
      // Merge with lower neighbor.
      S_PPWR: begin
        req.wr = 1'b1;
        req.addr = {4'd0, p_q};
        if (lo_merge) begin
          req.wdata = '{next: nn_q, size: psz_q + bsz_q};
        end else begin
          req.wdata = '{next: bp_q, size: psz_q};
        end
        rover_d = p_q;
        if (grow_q) begin
          // Resume the allocation walk one node past the new rover.
          grow_d = 1'b0;
          prev_d = p_q;
          p_d = lo_merge ? nn_q : bp_q;
          steps_d = steps_q + 19'd1;
          if (steps_q + 19'd1 > WALK_LIMIT) begin
            st_d = StNoMem;
            state_d = S_DONE;
          end else begin
            state_d = S_ARD;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      // Hold the result until the output register can take it.
      S_DONE: state_d = hold_i ? S_DONE : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign req_o = req;
  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign status_o = st_q;
  assign addr_o = (st_q == StOk) ? ad_q : 16'd0;
endmodule

[sv/free_list_allocator.sv]
// Top level of the next-fit free list allocator.
//  channel | dir | fields
//  s_axis  | in  | cmd, request_bytes, element_count, block_address, region_units
//  m_axis  | out | status, address
//  cfg     | in  | heap_limit (0), min_grow_units (1)
// One command at a time. After its transfer an allocation walks the free list
// from the rover; a free or donation walks the list to its insert point, and
// each growth writes a new header and runs an insert walk.
// The first command after reset also builds the sentinel.
// Reset clears control state; headers are undefined until written.
// A pending result is held in the output register; the next command is
// accepted while it waits, and its result waits for the slot to clear.
module free_list_allocator #(
  parameter int unsigned ARENA_UNITS = fla_pkg::ArenaUnitsDef,
  parameter int unsigned UNIT_BYTES  = fla_pkg::UnitBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0], request_bytes[22:2], element_count[38:23],
  // block_address[54:39], region_units[70:55]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], address[17:2]
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import fla_pkg::*;

  logic [15:0] heap_limit_q, min_grow_q;
  logic        busy, done, start, res_pend_q;
  logic        hold, take;
  logic [1:0]  st, res_st_q;
  logic [15:0] ad, res_ad_q;
  logic [36:0] bytes;
  mem_req_t    req;
  hdr_t        rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= HeapLimitRst;
      min_grow_q   <= MinGrowRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegHeapLimit) heap_limit_q <= cfg_data_i;
      if (cfg_idx_i == RegMinGrow)   min_grow_q   <= cfg_data_i;
    end
  end

  assign hold = res_pend_q && !m_axis_tready;
  assign take = done && !hold;

  assign s_axis_tready = !busy;
  assign start = s_axis_tvalid && s_axis_tready;
  assign bytes = (s_axis_tdata[1:0] == CmdArray) ?
                 37'(s_axis_tdata[38:23] * s_axis_tdata[22:2]) : {16'd0, s_axis_tdata[22:2]};

  fla_seq #(.ARENA_UNITS(ARENA_UNITS), .UNIT_BYTES(UNIT_BYTES)) u_seq (
    .clk_i, .rst_ni, .start_i(start), .hold_i(hold), .cmd_i(s_axis_tdata[1:0]),
    .bytes_i(bytes), .baddr_i(s_axis_tdata[54:39]), .region_i(s_axis_tdata[70:55]),
    .heap_limit_i(heap_limit_q), .min_grow_i(min_grow_q), .busy_o(busy),
    .done_o(done), .status_o(st), .addr_o(ad), .req_o(req), .rdata_i(rdata)
  );

  fla_hdr_mem #(.ARENA_UNITS(ARENA_UNITS)) u_mem (
    .clk_i, .req_i(req), .rdata_o(rdata)
  );

  // Hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_pend_q <= 1'b0;
    else if (take) res_pend_q <= 1'b1;
    else if (m_axis_tready) res_pend_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_st_q <= st;
      res_ad_q <= ad;
    end
  end

  assign m_axis_tvalid = res_pend_q;
  assign m_axis_tdata = {6'd0, res_ad_q, res_st_q};
endmodule

[tb/tb_free_list_allocator.sv]
// Testbench for the free list allocator: directed table, random traffic, predictor check.
`timescale 1ns / 100ps

module tb_free_list_allocator;
  import fla_pkg::*;

  localparam int unsigned WalkBound  = 2 * 65536 + 8;
  localparam int unsigned CycleLimit = 20000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] address;
  } alloc_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [20:0] bytes;
    logic [15:0] count;
    logic [15:0] baddr;
    logic [15:0] region;
    bit          pick_live;
    bit          typed;
    logic [1:0]  st;
    logic [15:0] ad;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  // Predictor state
  logic [15:0] hdr_next [65536];
  logic [16:0] hdr_size [65536];
  int unsigned rover_q;
  bit          list_up;
  int unsigned brk_q;
  int unsigned heap_limit_q;
  int unsigned min_grow_q;

  alloc_result_t pending_results[$];
  logic [15:0]   live_blocks[$];
  stim_row_t     rows[$];

  int unsigned cycle_cnt = 0;
  int          fail_cnt = 0;
  bit          hold_req = 1'b0;
  bit          donate_on = 1'b0;
  int unsigned donate_next;

  free_list_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Link a block into the address-ordered list, merging with neighbors
  function automatic int link_block(int unsigned bp);
    int unsigned p;
    int unsigned n;
    int unsigned steps;
    p = rover_q;
    steps = 0;
    if (hdr_size[bp] == 0) return int'(StInval);
    while (1) begin
      n = hdr_next[p];
      if (bp > p && bp < n) break;
      if (p >= n && (bp > p || bp < n)) break;
      p = n;
      steps++;
      if (steps > WalkBound) return int'(StInval);
    end
    n = hdr_next[p];
    if (bp + hdr_size[bp] == n) begin
      hdr_size[bp] = hdr_size[bp] + hdr_size[n];
      hdr_next[bp] = hdr_next[n];
    end else begin
      hdr_next[bp] = n[15:0];
    end
    if (p + hdr_size[p] == bp) begin
      hdr_size[p] = hdr_size[p] + hdr_size[bp];
      hdr_next[p] = hdr_next[bp];
    end else begin
      hdr_next[p] = bp[15:0];
    end
    rover_q = p & 16'hFFFF;
    return int'(StOk);
  endfunction

  // Take a fresh region from the break
  function automatic bit grow_heap(longint unsigned units);
    longint unsigned nu;
    longint unsigned cap;
    int unsigned hdr;
    nu = (units < min_grow_q) ? min_grow_q : units;
    cap = (heap_limit_q > 65535) ? 65535 : heap_limit_q;
    if (brk_q + nu > cap + 1) return 1'b0;
    hdr = brk_q;
    hdr_size[hdr] = nu[16:0];
    brk_q = brk_q + int'(nu);
    return link_block(hdr) == int'(StOk);
  endfunction

  // Next-fit search; split from the tail of a larger block
  function automatic alloc_result_t carve_block(longint unsigned bytes);
    alloc_result_t r;
    longint unsigned units;
    int unsigned prev;
    int unsigned p;
    int unsigned sz;
    int unsigned steps;
    r.status = StOk;
    r.address = '0;
    steps = 0;
    if (bytes == 0) begin
      r.status = StInval;
      return r;
    end
    units = (bytes + 15) / 16 + 1;
    prev = rover_q;
    p = hdr_next[prev];
    while (1) begin
      sz = hdr_size[p];
      if (sz >= units) begin
        if (sz == units) begin
          hdr_next[prev] = hdr_next[p];
        end else begin
          sz = sz - int'(units);
          hdr_size[p] = sz[16:0];
          p = p + sz;
          hdr_size[p] = units[16:0];
        end
        rover_q = prev & 16'hFFFF;
        r.address = 16'(p + 1);
        return r;
      end
      if (p == rover_q) begin
        if (!grow_heap(units)) begin
          r.status = StNoMem;
          return r;
        end
        p = rover_q;
      end
      prev = p;
      p = hdr_next[p];
      steps++;
      if (steps > WalkBound) begin
        r.status = StNoMem;
        return r;
      end
    end
  endfunction

  // Predict the result of one command
  function automatic alloc_result_t heap_step(logic [1:0] cmd, logic [20:0] bytes,
                                              logic [15:0] count, logic [15:0] baddr,
                                              logic [15:0] region);
    alloc_result_t r;
    logic [15:0] hdr;
    r = '0;
    if (!list_up) begin
      hdr_next[0] = '0;
      hdr_size[0] = '0;
      rover_q = 0;
      list_up = 1'b1;
    end
    case (cmd)
      CmdAlloc: r = carve_block(longint'(bytes));
      CmdFree: begin
        hdr = baddr - 16'd1;
        r.status = 2'(link_block(hdr));
      end
      CmdDonate: begin
        hdr_size[baddr] = {1'b0, region};
        r.status = 2'(link_block(baddr));
      end
      default: r = carve_block(longint'(count) * longint'(bytes));
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] take_live(bit newest);
    int idx;
    logic [15:0] a;
    idx = newest ? live_blocks.size() - 1 : $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[idx];
    live_blocks.delete(idx);
    return a;
  endfunction

  function automatic void add_row(logic [1:0] cmd, logic [20:0] bytes, logic [15:0] count,
                                  logic [15:0] baddr, bit pick_live, bit typed,
                                  logic [1:0] st);
    stim_row_t r;
    r.cmd = cmd;
    r.bytes = bytes;
    r.count = count;
    r.baddr = baddr;
    r.region = '0;
    r.pick_live = pick_live;
    r.typed = typed;
    r.st = st;
    r.ad = '0;
    rows.push_back(r);
  endfunction

  // Offer one command, predict at its transfer, then idle a random gap, maybe none
  task automatic send_cmd(logic [1:0] cmd, logic [20:0] bytes, logic [15:0] count,
                          logic [15:0] baddr, logic [15:0] region, bit typed,
                          alloc_result_t typed_res);
    alloc_result_t r;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, region, baddr, count, bytes, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = heap_step(cmd, bytes, count, baddr, region);
    if ((cmd == CmdAlloc || cmd == CmdArray) && r.status == StOk)
      live_blocks.push_back(r.address);
    pending_results.push_back(typed ? typed_res : r);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every expected result has arrived
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegHeapLimit) heap_limit_q = val;
    else min_grow_q = val;
    @(posedge clk_i);
  endtask

  // Random traffic: mostly small allocations and frees of live blocks
  task automatic run_random(int n, bit with_hold);
    int roll;
    logic [1:0] cmd;
    logic [20:0] bytes;
    logic [15:0] count;
    logic [15:0] baddr;
    logic [15:0] region;
    alloc_result_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == 40) hold_req = 1'b1;
      roll = $urandom_range(0, 99);
      bytes = 21'($urandom());
      count = 16'($urandom());
      baddr = 16'($urandom());
      region = 16'($urandom());
      if (roll < 70) begin
        if ($urandom_range(0, 99) < 15) cmd = CmdArray;
        else cmd = CmdAlloc;
      end else if (roll < 95) begin
        cmd = CmdFree;
      end else begin
        cmd = CmdDonate;
      end
      if (cmd == CmdFree && live_blocks.size() == 0) cmd = CmdAlloc;
      if (cmd == CmdDonate && !donate_on) cmd = CmdAlloc;
      case (cmd)
        CmdAlloc: begin
          roll = $urandom_range(0, 99);
          if (roll < 70) bytes = 21'($urandom_range(1, 64));
          else if (roll < 90) bytes = 21'($urandom_range(1, 1024));
          else if (roll < 95) bytes = 21'($urandom_range(1, 16384));
          else bytes = 21'($urandom_range(0, 21'hFFFFF));
        end
        CmdArray: begin
          if ($urandom_range(0, 99) < 90) begin
            count = 16'($urandom_range(1, 16));
            bytes = 21'($urandom_range(1, 64));
          end else begin
            bytes = 21'($urandom_range(0, 21'hFFFFF));
          end
        end
        CmdFree: begin
          // Freeing the sentinel is refused without touching the list
          if ($urandom_range(0, 99) < 3) baddr = 16'd1;
          else baddr = take_live(1'b0);
        end
        default: begin
          region = 16'($urandom_range(1, 64));
          if ($urandom_range(0, 99) < 8) region = '0;
          if (donate_next + region > 65536) begin
            cmd = CmdAlloc;
            bytes = 21'($urandom_range(1, 64));
          end else begin
            baddr = donate_next[15:0];
            donate_next = donate_next + region;
          end
        end
      endcase
      send_cmd(cmd, bytes, count, baddr, region, 1'b0, none);
    end
  endtask

  // Receive side: random stalls, one long hold-off on request
  initial begin : sink
    int stall_left;
    alloc_result_t got;
    alloc_result_t want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[1:0], m_axis_tdata[17:2]};
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: status %0d address %0d",
                 got.status, got.address);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_cnt++;
          end
          if (got.address !== want.address) begin
            $error("address: expected %0d, actual %0d", want.address, got.address);
            fail_cnt++;
          end
        end
      end
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < 15) stall_left = pick_gap();
      end
    end
  end

  initial begin : source
    alloc_result_t tr;
    logic [15:0] a;
    int unsigned hl;
    for (int i = 0; i < 65536; i++) begin
      hdr_next[i] = '0;
      hdr_size[i] = '0;
    end
    rover_q = 0;
    list_up = 1'b0;
    brk_q = 1;
    heap_limit_q = HeapLimitRst;
    min_grow_q = MinGrowRst;

    // Directed rows: error codes typed in, the rest predicted
    add_row(CmdAlloc, 21'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, StInval);
    add_row(CmdArray, 21'd5, 16'd0, 16'd0, 1'b0, 1'b1, StInval);
    add_row(CmdArray, 21'd0, 16'd7, 16'd0, 1'b0, 1'b1, StInval);
    add_row(CmdArray, 21'd1048576, 16'hFFFF, 16'd0, 1'b0, 1'b1, StNoMem);
    add_row(CmdAlloc, 21'd1048576, 16'd0, 16'd0, 1'b0, 1'b1, StNoMem);
    add_row(CmdFree, 21'd0, 16'd0, 16'd1, 1'b0, 1'b1, StInval);
    add_row(CmdAlloc, 21'd1, 16'd0, 16'd0, 1'b0, 1'b0, StOk);
    add_row(CmdAlloc, 21'd16, 16'd0, 16'd0, 1'b0, 1'b0, StOk);
    add_row(CmdAlloc, 21'd17, 16'd0, 16'd0, 1'b0, 1'b0, StOk);
    add_row(CmdArray, 21'd100, 16'd3, 16'd0, 1'b0, 1'b0, StOk);
    add_row(CmdFree, 21'd0, 16'd0, 16'd0, 1'b1, 1'b0, StOk);
    add_row(CmdFree, 21'd0, 16'd0, 16'd0, 1'b1, 1'b0, StOk);
    add_row(CmdAlloc, 21'd16352, 16'd0, 16'd0, 1'b0, 1'b0, StOk);
    add_row(CmdAlloc, 21'd1, 16'd0, 16'd0, 1'b0, 1'b0, StOk);
    add_row(CmdFree, 21'd0, 16'd0, 16'd0, 1'b1, 1'b0, StOk);
    add_row(CmdArray, 21'd1, 16'd65535, 16'd0, 1'b0, 1'b0, StOk);
    add_row(CmdFree, 21'd0, 16'd0, 16'd0, 1'b1, 1'b0, StOk);
    add_row(CmdFree, 21'd0, 16'd0, 16'd0, 1'b1, 1'b0, StOk);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the directed table
    foreach (rows[i]) begin
      a = rows[i].baddr;
      if (rows[i].pick_live && live_blocks.size() != 0) a = take_live(1'b1);
      tr.status = rows[i].st;
      tr.address = rows[i].ad;
      send_cmd(rows[i].cmd, rows[i].bytes, rows[i].count, a, rows[i].region,
               rows[i].typed, tr);
    end
    run_random(250, 1'b1);
    drain();

    // Smallest growth step
    write_reg(RegMinGrow, 16'd1);
    run_random(250, 1'b0);
    drain();

    // Largest growth step: growth never fits
    write_reg(RegMinGrow, 16'hFFFF);
    run_random(200, 1'b0);
    drain();

    // Lowest heap limit: no growth at all
    write_reg(RegHeapLimit, 16'd1);
    write_reg(RegMinGrow, MinGrowRst);
    run_random(200, 1'b0);
    drain();

    // Cap growth below a donation area that sits above the limit
    hl = brk_q + 3000;
    if (hl > 60000) hl = 60000;
    if (hl < brk_q) hl = brk_q;
    write_reg(RegHeapLimit, hl[15:0]);
    write_reg(RegMinGrow, 16'd1);
    donate_next = hl + 1;
    donate_on = (hl + 1 < 65000);
    run_random(300, 1'b0);
    drain();

    write_reg(RegMinGrow, 16'($urandom_range(2, 2048)));
    run_random(300, 1'b0);
    drain();

    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
